// File: rtl/tlcd_pkg.sv
// Shared types, constants and the Cyrillic recoding table for the LCD text formatter.
`timescale 1ns / 1ps

package tlcd_pkg;

  // Display geometry
  localparam int Rows = 2;
  localparam int Cols = 16;

  localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int ColW = $clog2(Cols + 1);

  // Controller command bytes
  localparam logic [7:0] CmdFunctionSet = 8'h3C;
  localparam logic [7:0] CmdDisplayOn   = 8'h0C;
  localparam logic [7:0] CmdClear       = 8'h01;
  localparam logic [7:0] CmdEntryMode   = 8'h06;
  localparam logic [7:0] CmdSetAddr     = 8'h80;
  localparam logic [7:0] CyrFirst       = 8'd192;

  // Cursor mode codes
  localparam logic [7:0] CursorModeMax     = 8'd3;
  localparam logic [1:0] CursorModeDefault = 2'd2;

  // Init sequence step codes
  localparam logic [2:0] InitStepFunction      = 3'd0;
  localparam logic [2:0] InitStepFunctionAgain = 3'd1;
  localparam logic [2:0] InitStepDisplay       = 3'd2;
  localparam logic [2:0] InitStepClear         = 3'd3;
  localparam logic [2:0] InitStepLast          = 3'd4;

  typedef enum logic [2:0] {
    OP_PUT_CHAR   = 3'd0,
    OP_CLEAR      = 3'd1,
    OP_SET_POS    = 3'd2,
    OP_SET_CURSOR = 3'd3,
    OP_INIT       = 3'd4
  } op_e;

  localparam logic [7:0] CyrRom [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'h33,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  // Recode a Windows-1251 byte for the display character generator
  function automatic logic [7:0] recode_char(logic [7:0] ch);
    logic [7:0] res;
    if (ch < CyrFirst) begin
      res = ch;
    end else begin
      res = CyrRom[ch[5:0]];
    end
    return res;
  endfunction

endpackage

// File: rtl/text_to_char_lcd_commands_unit.sv
// Top level: formats display operations into the command/data byte stream of a character LCD.
// An accepted operation is held in the operation register; each of its results is computed from
// it and loaded into the output register. Throughput: one result per cycle while the output
// register is free; put_char yields one result, or two when the line wraps, init yields five,
// clear/set_pos/set_cursor yield one, and unknown ops are dropped without a result or a wait.
// Reset (rst_ni low, asynchronous) empties both registers and homes the cursor to 0,0.
`timescale 1ns / 1ps

module text_to_char_lcd_commands_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // op[2:0], char_code[10:3], target_row[18:11], target_col[26:19], cursor_mode[34:27], zero
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // lcd_byte[7:0], cursor_row[8], cursor_col[13:9], zero
  output logic [15:0] m_axis_tdata_o,
  // is_data[0]
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int RowW = tlcd_pkg::RowW;
  localparam int ColW = tlcd_pkg::ColW;

  // Held operation
  logic       item_vld_q;
  logic [2:0] op_q;
  logic [7:0] char_q, trow_q, tcol_q, mode_q;
  logic [2:0] idx_q;

  // Cursor state
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;

  // Output register
  logic       out_vld_q;
  logic [7:0] out_byte_q, byte_d;
  logic       out_data_q, data_d;
  logic       out_row_q;
  logic [4:0] out_col_q;
  logic       out_last_q, last_d;

  logic out_free, known, step, release_item;
  logic [RowW-1:0] trow_clamp;
  logic [ColW-1:0] tcol_clamp;
  logic [1:0]      mode_fix;

  assign out_free     = !out_vld_q || m_axis_tready_i;
  assign step         = item_vld_q && (out_free || !known);
  assign release_item = step && (last_d || !known);

  assign s_axis_tready_o = !item_vld_q || release_item;

  // Clamp set_pos targets and fix cursor mode
  always_comb begin
    if (trow_q > 8'(tlcd_pkg::Rows - 1)) begin
      trow_clamp = RowW'(tlcd_pkg::Rows - 1);
    end else begin
      trow_clamp = trow_q[RowW-1:0];
    end
    if (tcol_q > 8'(tlcd_pkg::Cols - 1)) begin
      tcol_clamp = ColW'(tlcd_pkg::Cols - 1);
    end else begin
      tcol_clamp = tcol_q[ColW-1:0];
    end
    if (mode_q > tlcd_pkg::CursorModeMax) begin
      mode_fix = tlcd_pkg::CursorModeDefault;
    end else begin
      mode_fix = mode_q[1:0];
    end
  end

  // Compute the next result and the cursor after it
  always_comb begin
    known  = 1'b1;
    byte_d = '0;
    data_d = 1'b0;
    last_d = 1'b1;
    row_d  = row_q;
    col_d  = col_q;
    unique case (op_q)
      tlcd_pkg::OP_PUT_CHAR: begin
        if (col_q >= ColW'(tlcd_pkg::Cols)) begin
          // wrap to next line, or to the top from the last line
          if (row_q == RowW'(tlcd_pkg::Rows - 1)) begin
            row_d = '0;
          end else begin
            row_d = row_q + RowW'(1);
          end
          col_d  = '0;
          byte_d = tlcd_pkg::CmdSetAddr | 8'({row_d, 6'b0});
          last_d = 1'b0;
        end else begin
          col_d  = col_q + ColW'(1);
          byte_d = tlcd_pkg::recode_char(char_q);
          data_d = 1'b1;
        end
      end
      tlcd_pkg::OP_CLEAR: begin
        row_d  = '0;
        col_d  = '0;
        byte_d = tlcd_pkg::CmdClear;
      end
      tlcd_pkg::OP_SET_POS: begin
        row_d  = trow_clamp;
        col_d  = tcol_clamp;
        byte_d = tlcd_pkg::CmdSetAddr | (8'({trow_clamp, 6'b0}) + 8'(tcol_clamp));
      end
      tlcd_pkg::OP_SET_CURSOR: begin
        byte_d = tlcd_pkg::CmdDisplayOn | {6'b0, mode_fix};
      end
      tlcd_pkg::OP_INIT: begin
        last_d = (idx_q == tlcd_pkg::InitStepLast);
        case (idx_q)
          tlcd_pkg::InitStepFunction,
          tlcd_pkg::InitStepFunctionAgain: byte_d = tlcd_pkg::CmdFunctionSet;
          tlcd_pkg::InitStepDisplay:       byte_d = tlcd_pkg::CmdDisplayOn;
          tlcd_pkg::InitStepClear: begin
            byte_d = tlcd_pkg::CmdClear;
            row_d  = '0;
            col_d  = '0;
          end
          default:    byte_d = tlcd_pkg::CmdEntryMode;
        endcase
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Operation register, step counter and cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      idx_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else begin
      if (step && known) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        item_vld_q <= 1'b1;
        idx_q      <= '0;
      end else if (release_item) begin
        item_vld_q <= 1'b0;
        idx_q      <= '0;
      end else if (step) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  // Capture the incoming transaction payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      op_q   <= s_axis_tdata_i[2:0];
      char_q <= s_axis_tdata_i[10:3];
      trow_q <= s_axis_tdata_i[18:11];
      tcol_q <= s_axis_tdata_i[26:19];
      mode_q <= s_axis_tdata_i[34:27];
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && known) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (step && known) begin
      out_byte_q <= byte_d;
      out_data_q <= data_d;
      out_row_q  <= row_d[0];
      out_col_q  <= 5'(col_d);
      out_last_q <= last_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b0, out_col_q, out_row_q, out_byte_q};
  assign m_axis_tuser_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the character LCD text formatter.
`timescale 1ns / 1ps

module testbench;

  localparam int RandomItems = 288;
  localparam int HoldCycles  = 90;
  localparam int DrainCycles = 16;
  localparam int CycleLimit  = 100000;

  // Op codes the block must drop without a result
  localparam logic [2:0] OpSpare5 = 3'd5;
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  // Windows-1251 0xC0..0xFF to display character generator codes
  localparam logic [7:0] CyrGlyph [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'h33,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       cursor_row;
    logic [4:0] cursor_col;
    logic       last;
  } lcd_write_t;

  // One directed operation; typed rows carry the single write they must produce
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] char_code;
    logic [7:0] target_row;
    logic [7:0] target_col;
    logic [7:0] cursor_mode;
    logic       typed;
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       cursor_row;
    logic [4:0] cursor_col;
  } lcd_vector_t;

  localparam lcd_vector_t DirectedOps [24] = '{
    '{tlcd_pkg::OP_CLEAR,      8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h01, 1'b0, 1'b0, 5'd0},
    '{tlcd_pkg::OP_INIT,       8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0},
    '{tlcd_pkg::OP_SET_CURSOR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h0C, 1'b0, 1'b0, 5'd0},
    '{tlcd_pkg::OP_SET_CURSOR, 8'h00, 8'h00, 8'h00, 8'h03, 1'b1, 8'h0F, 1'b0, 1'b0, 5'd0},
    '{tlcd_pkg::OP_SET_CURSOR, 8'h00, 8'h00, 8'h00, 8'h04, 1'b1, 8'h0E, 1'b0, 1'b0, 5'd0},
    '{tlcd_pkg::OP_SET_CURSOR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h0E, 1'b0, 1'b0, 5'd0},
    '{tlcd_pkg::OP_SET_POS,    8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1, 8'hCF, 1'b0, 1'b1, 5'd15},
    '{tlcd_pkg::OP_PUT_CHAR,   8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'hC7, 1'b1, 1'b1, 5'd16},
    '{tlcd_pkg::OP_PUT_CHAR,   8'hC0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0},
    '{tlcd_pkg::OP_SET_POS,    8'h00, 8'h00, 8'hFF, 8'h00, 1'b1, 8'h8F, 1'b0, 1'b0, 5'd15},
    '{tlcd_pkg::OP_PUT_CHAR,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 5'd16},
    '{tlcd_pkg::OP_PUT_CHAR,   8'hBF, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0},
    '{tlcd_pkg::OP_SET_POS,    8'h00, 8'h01, 8'h00, 8'h00, 1'b1, 8'hC0, 1'b0, 1'b1, 5'd0},
    '{tlcd_pkg::OP_SET_POS,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h80, 1'b0, 1'b0, 5'd0},
    '{tlcd_pkg::OP_PUT_CHAR,   8'hDA, 8'h00, 8'h00, 8'h00, 1'b1, 8'hAD, 1'b1, 1'b0, 5'd1},
    '{tlcd_pkg::OP_PUT_CHAR,   8'hE9, 8'h00, 8'h00, 8'h00, 1'b1, 8'hB9, 1'b1, 1'b0, 5'd2},
    '{tlcd_pkg::OP_PUT_CHAR,   8'hF5, 8'h00, 8'h00, 8'h00, 1'b1, 8'h78, 1'b1, 1'b0, 5'd3},
    '{OpSpare5,                8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0},
    '{OpSpare7,                8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0},
    '{OpSpare6,                8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0},
    '{tlcd_pkg::OP_SET_POS,    8'h00, 8'h02, 8'h10, 8'h00, 1'b1, 8'hCF, 1'b0, 1'b1, 5'd15},
    '{tlcd_pkg::OP_PUT_CHAR,   8'h7F, 8'h00, 8'h00, 8'h00, 1'b1, 8'h7F, 1'b1, 1'b1, 5'd16},
    '{tlcd_pkg::OP_CLEAR,      8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h01, 1'b0, 1'b0, 5'd0},
    '{tlcd_pkg::OP_INIT,       8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Cursor as the display should track it
  int cursor_row_q;
  int cursor_col_q;

  lcd_write_t lcd_writes_q[$];

  int phase;
  int send_idle_pct;
  int recv_idle_pct;
  int fail_cnt;
  int ops_sent;
  int ops_dropped;
  int wraps_seen;
  int writes_checked;
  int cycle_cnt;

  text_to_char_lcd_commands_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Queue one predicted write stamped with the current cursor
  function automatic void push_write(logic [7:0] lcd_byte, logic is_data, logic last);
    lcd_write_t w;
    w.lcd_byte   = lcd_byte;
    w.is_data    = is_data;
    w.cursor_row = cursor_row_q[0];
    w.cursor_col = cursor_col_q[4:0];
    w.last       = last;
    lcd_writes_q.push_back(w);
  endfunction

  function automatic logic [7:0] ddram_addr_cmd();
    int addr;
    addr = 'h80 | (64 * cursor_row_q + cursor_col_q);
    return addr[7:0];
  endfunction

  // Predict the write sequence of one operation and advance the cursor
  function automatic void format_op(logic [2:0] op, logic [7:0] char_code,
                                    logic [7:0] target_row, logic [7:0] target_col,
                                    logic [7:0] cursor_mode);
    logic [7:0] glyph;
    logic [7:0] mode;
    case (op)
      tlcd_pkg::OP_PUT_CHAR: begin
        if (cursor_col_q >= tlcd_pkg::Cols) begin
          // wrap to the next line, or back to the top from the last one
          cursor_row_q = (cursor_row_q < tlcd_pkg::Rows - 1) ? cursor_row_q + 1 : 0;
          cursor_col_q = 0;
          wraps_seen++;
          push_write(ddram_addr_cmd(), 1'b0, 1'b0);
        end
        cursor_col_q++;
        glyph = (char_code < 8'd192) ? char_code : CyrGlyph[char_code - 8'd192];
        push_write(glyph, 1'b1, 1'b1);
      end
      tlcd_pkg::OP_CLEAR: begin
        cursor_row_q = 0;
        cursor_col_q = 0;
        push_write(8'h01, 1'b0, 1'b1);
      end
      tlcd_pkg::OP_SET_POS: begin
        cursor_row_q = (target_row > tlcd_pkg::Rows - 1) ? tlcd_pkg::Rows - 1
                                                          : int'(target_row);
        cursor_col_q = (target_col > tlcd_pkg::Cols - 1) ? tlcd_pkg::Cols - 1
                                                          : int'(target_col);
        push_write(ddram_addr_cmd(), 1'b0, 1'b1);
      end
      tlcd_pkg::OP_SET_CURSOR: begin
        mode = (cursor_mode > 8'd3) ? 8'd2 : cursor_mode;
        push_write(8'h0C | mode, 1'b0, 1'b1);
      end
      tlcd_pkg::OP_INIT: begin
        push_write(8'h3C, 1'b0, 1'b0);
        push_write(8'h3C, 1'b0, 1'b0);
        push_write(8'h0C, 1'b0, 1'b0);
        cursor_row_q = 0;
        cursor_col_q = 0;
        push_write(8'h01, 1'b0, 1'b0);
        push_write(8'h06, 1'b0, 1'b1);
      end
      default: begin
        ops_dropped++;
      end
    endcase
  endfunction

  function automatic void set_phase(int p);
    phase = p;
    case (p)
      0: begin
        send_idle_pct = 23;
        recv_idle_pct = 54;
      end
      1: begin
        send_idle_pct = 54;
        recv_idle_pct = 23;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  // Offer one operation, wait for its transaction, then predict it
  task automatic send_op(logic [2:0] op, logic [7:0] char_code, logic [7:0] target_row,
                         logic [7:0] target_col, logic [7:0] cursor_mode);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, cursor_mode, target_col, target_row, char_code, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ops_sent++;
    format_op(op, char_code, target_row, target_col, cursor_mode);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Receiver: check each write transaction and drive tready
  initial begin : lcd_sink
    int hold_left;
    bit hold_done;
    lcd_write_t want;
    hold_left = 0;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (lcd_writes_q.size() == 0) begin
          $error("unexpected write 0x%0h with nothing pending", m_axis_tdata[7:0]);
          fail_cnt++;
        end else begin
          want = lcd_writes_q.pop_front();
          writes_checked++;
          check_field("lcd_byte", want.lcd_byte, m_axis_tdata[7:0]);
          check_field("is_data", want.is_data, m_axis_tuser);
          check_field("cursor_row", want.cursor_row, m_axis_tdata[8]);
          check_field("cursor_col", want.cursor_col, m_axis_tdata[13:9]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      // hold off for a long stretch once the sender runs flat out
      if (phase == 2 && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    lcd_write_t typed_write;
    logic [2:0] op;
    logic [7:0] target_row;
    logic [7:0] target_col;
    logic [7:0] cursor_mode;
    int pick;
    int counted;
    fail_cnt       = 0;
    ops_sent       = 0;
    ops_dropped    = 0;
    wraps_seen     = 0;
    writes_checked = 0;
    cursor_row_q   = 0;
    cursor_col_q   = 0;
    set_phase(0);
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every op, wraps, Cyrillic glyphs, dropped op codes
    foreach (DirectedOps[i]) begin
      send_op(DirectedOps[i].op, DirectedOps[i].char_code, DirectedOps[i].target_row,
              DirectedOps[i].target_col, DirectedOps[i].cursor_mode);
      if (DirectedOps[i].typed) begin
        typed_write.lcd_byte   = DirectedOps[i].lcd_byte;
        typed_write.is_data    = DirectedOps[i].is_data;
        typed_write.cursor_row = DirectedOps[i].cursor_row;
        typed_write.cursor_col = DirectedOps[i].cursor_col;
        typed_write.last       = 1'b1;
        void'(lcd_writes_q.pop_back());
        lcd_writes_q.push_back(typed_write);
      end
    end

    // Random: mostly text to force line wraps, with positioning and control ops
    for (int p = 0; p < 3; p++) begin
      set_phase(p);
      counted = 0;
      while (counted < RandomItems / 3) begin
        pick        = $urandom_range(99);
        target_row  = 8'($urandom_range(255));
        target_col  = 8'($urandom_range(255));
        cursor_mode = 8'($urandom_range(255));
        if (pick < 55) begin
          op = tlcd_pkg::OP_PUT_CHAR;
        end else if (pick < 67) begin
          op = tlcd_pkg::OP_SET_POS;
          if ($urandom_range(1)) begin
            target_row = 8'($urandom_range(tlcd_pkg::Rows - 1));
            target_col = 8'($urandom_range(tlcd_pkg::Cols - 1));
          end
        end else if (pick < 77) begin
          op = tlcd_pkg::OP_SET_CURSOR;
          if ($urandom_range(1)) cursor_mode = 8'($urandom_range(3));
        end else if (pick < 82) begin
          op = tlcd_pkg::OP_CLEAR;
        end else if (pick < 87) begin
          op = tlcd_pkg::OP_INIT;
        end else begin
          op = 3'($urandom_range(7, 5));
        end
        send_op(op, 8'($urandom_range(255)), target_row, target_col, cursor_mode);
        counted++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then watch for stray writes
    while (lcd_writes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d operations (%0d dropped op codes, %0d line wraps), checked %0d writes",
             ops_sent, ops_dropped, wraps_seen, writes_checked);
    $display("Idle mixes: sender-heavy, receiver-heavy, none; one %0d-cycle receiver hold",
             HoldCycles);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
